>>> rtl/des_ofb_stream_cipher_top_assert.svh
// Assertion macros used by the DES OFB cipher top
`ifndef DES_OFB_STREAM_CIPHER_TOP_ASSERT_SVH
`define DES_OFB_STREAM_CIPHER_TOP_ASSERT_SVH
// Same-cycle implication, clocked on clk, off during reset
`define DESOFB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, clocked on clk, off during reset
`define DESOFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/desofb_pkg.sv
// Package: DES tables, round functions and the per-cell state type
package desofb_pkg;

    localparam int NUM_ROUNDS = 16;

    // Configuration register indexes
    localparam logic CFG_KEY = 1'b0;
    localparam logic CFG_IV  = 1'b1;

    typedef struct packed {
        logic        valid;
        logic        last;
        logic [31:0] l;
        logic [31:0] r;
        logic [27:0] c;
        logic [27:0] d;
        logic [63:0] pt;
    } cell_t;

    localparam int TAB_IP [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7 };

    localparam int TAB_FP [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25 };

    localparam int TAB_E [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1 };

    localparam int TAB_P [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25 };

    localparam int TAB_PC1 [56] = '{
        57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
        60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,
        61,53,45,37,29,21,13,5,28,20,12,4 };

    localparam int TAB_PC2 [48] = '{
        14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
        41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32 };

    localparam int TAB_ROT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    localparam logic [3:0] SBOX [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11} };

    // Table positions count from 1 at the most significant bit
    function automatic logic [63:0] perm_ip(input logic [63:0] x);
        logic [63:0] y;
        for (int i = 0; i < 64; i++) y[63-i] = x[64-TAB_IP[i]];
        return y;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] x);
        logic [63:0] y;
        for (int i = 0; i < 64; i++) y[63-i] = x[64-TAB_FP[i]];
        return y;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] x);
        logic [55:0] y;
        for (int i = 0; i < 56; i++) y[55-i] = x[64-TAB_PC1[i]];
        return y;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] x);
        logic [47:0] y;
        for (int i = 0; i < 48; i++) y[47-i] = x[56-TAB_PC2[i]];
        return y;
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] x;
        logic [31:0] s;
        logic [5:0]  six;
        logic [31:0] y;
        for (int i = 0; i < 48; i++) x[47-i] = r[32-TAB_E[i]];
        x = x ^ k;
        for (int b = 0; b < 8; b++)
        begin
            six = x[47-6*b -: 6];
            s[31-4*b -: 4] = SBOX[b][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) y[31-i] = s[32-TAB_P[i]];
        return y;
    endfunction

endpackage

>>> rtl/desofb_in_if.sv
// Interface: plaintext input channel
interface desofb_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] plaintext_block;
    logic        start_of_message;

    modport source (output valid, plaintext_block, start_of_message, input ready);
    modport sink   (input valid, plaintext_block, start_of_message, output ready);
endinterface

>>> rtl/desofb_out_if.sv
// Interface: ciphertext output channel
interface desofb_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] ciphertext_block;

    modport source (output valid, ciphertext_block, input ready);
    modport sink   (input valid, ciphertext_block, output ready);
endinterface

>>> rtl/des_ofb_stream_cipher_top.sv
// Top level: DES output feedback cipher over a chain of sixteen round cells
//
//   channel   dir  handshake        payload
//   din       in   valid/ready      plaintext_block[63:0], start_of_message
//   dout      out  valid/ready      ciphertext_block[63:0]
//   cfg       in   cfg_we           cfg_index (0 key, 1 IV), cfg_data[63:0]
//
// A beat crosses 16 round cells plus the output register.
// A beat that starts a message may enter right behind any beat while the chain
// advances; a beat that continues one waits for the previous keystream to leave
// the chain, so within a message only one beat is in the chain at a time.
// Reset clears key, IV, feedback and all valid bits. A stalled output freezes
// the whole chain.
`include "des_ofb_stream_cipher_top_assert.svh"
module des_ofb_stream_cipher_top
    import desofb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_data,
    desofb_in_if.sink    din,
    desofb_out_if.source dout
);

    logic [63:0] key_reg;
    logic [63:0] iv_reg;
    logic [63:0] fb_reg;
    logic        out_valid_reg;
    logic [63:0] out_data_reg;

    cell_t       head;
    cell_t       stage [1:NUM_ROUNDS];
    logic        advance;
    logic        pending;
    logic        accept;
    logic [63:0] fb_src;
    logic [55:0] cd0;
    logic [63:0] lr0;
    logic [63:0] ks;
    logic        tail_exit;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            iv_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY: key_reg <= cfg_data;
                CFG_IV:  iv_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Youngest beat still in the chain blocks a continuing beat
    always_comb
    begin
        pending = 1'b0;
        for (int i = 1; i <= NUM_ROUNDS; i++)
            pending = pending | (stage[i].valid & stage[i].last);
    end

    assign advance  = !out_valid_reg || dout.ready;
    assign din.ready = advance && (!pending || din.start_of_message);
    assign accept   = din.valid && din.ready;

    // Load the chain head: initial permutation and key halves
    always_comb
    begin
        fb_src     = din.start_of_message ? iv_reg : fb_reg;
        cd0        = perm_pc1(key_reg);
        lr0        = perm_ip(fb_src);
        head       = '0;
        head.valid = accept;
        head.last  = accept;
        head.l     = lr0[63:32];
        head.r     = lr0[31:0];
        head.c     = cd0[55:28];
        head.d     = cd0[27:0];
        head.pt    = din.plaintext_block;
    end

    // Round cells; a new beat takes the tail mark from older ones
    for (genvar g = 0; g < NUM_ROUNDS; g++)
    begin : g_cell
        cell_t link;
        if (g == 0)
        begin : g_first
            assign link = head;
        end
        else
        begin : g_rest
            always_comb
            begin
                link = stage[g];
                if (accept)
                    link.last = 1'b0;
            end
        end
        desofb_round_cell #(.ROT(TAB_ROT[g])) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .prev    (link),
            .cur_reg (stage[g+1])
        );
    end

    assign ks        = perm_fp({stage[NUM_ROUNDS].r, stage[NUM_ROUNDS].l});
    assign tail_exit = advance && stage[NUM_ROUNDS].valid && stage[NUM_ROUNDS].last;

    // Feedback: take the keystream of the youngest beat as it leaves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fb_reg <= '0;
        else if (tail_exit)
            fb_reg <= ks;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= stage[NUM_ROUNDS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= stage[NUM_ROUNDS].pt ^ ks;
    end

    assign dout.valid            = out_valid_reg;
    assign dout.ciphertext_block = out_data_reg;

    logic [NUM_ROUNDS-1:0] tail_vec;
    always_comb
    begin
        for (int i = 0; i < NUM_ROUNDS; i++)
            tail_vec[i] = stage[i+1].valid & stage[i+1].last;
    end

    `DESOFB_ASSERT_NOW(a_one_tail, 1'b1, $onehot0(tail_vec), "more than one tail beat")
    `DESOFB_ASSERT_NEXT(a_accept_tail, accept, pending, "accepted beat not marked tail")
    `DESOFB_ASSERT_NEXT(a_exit_out, advance && stage[NUM_ROUNDS].valid, out_valid_reg, "lost beat")

endmodule

>>> rtl/desofb_round_cell.sv
// Module: one DES round cell, holds a block in flight and its key schedule
module desofb_round_cell
    import desofb_pkg::*;
#(
    parameter int ROT = 1
)(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  advance,
    input  cell_t prev,
    output cell_t cur_reg
);

    logic [27:0] c_rot;
    logic [27:0] d_rot;
    logic [47:0] subkey;
    cell_t       cur_next;

    // Rotate key halves, derive subkey, run one Feistel round
    always_comb
    begin
        c_rot    = {prev.c[27-ROT:0], prev.c[27:28-ROT]};
        d_rot    = {prev.d[27-ROT:0], prev.d[27:28-ROT]};
        subkey   = perm_pc2({c_rot, d_rot});
        cur_next = prev;
        cur_next.c = c_rot;
        cur_next.d = d_rot;
        cur_next.l = prev.r;
        cur_next.r = prev.l ^ feistel(prev.r, subkey);
    end

    // Advance the whole cell with the chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_reg <= '0;
        else if (advance)
            cur_reg <= cur_next;
    end

endmodule

>>> test/tb_des_ofb_stream_cipher_top.sv
// Testbench for the DES OFB cipher top: directed and random messages checked against a DES model
`timescale 1ns / 1ps
module tb_des_ofb_stream_cipher_top
    import desofb_pkg::*;
();

    localparam int   IDLE_LIMIT = 5000;
    localparam int   DRAIN_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [63:0] cfg_data;

    desofb_in_if  din ();
    desofb_out_if dout ();

    des_ofb_stream_cipher_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .din       (din.sink),
        .dout      (dout.source)
    );

    // Cipher state as the block should hold it
    logic [63:0] key_shadow;
    logic [63:0] iv_shadow;
    logic [63:0] feedback_shadow;
    logic [63:0] cipher_expected [$];

    int  mismatch_count;
    bit  send_gaps;
    bit  sink_stalls;
    bit  long_hold_req;
    int  hold_left = 0;
    int  stall_left = 0;
    int  idle_cycles = 0;

    // Clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // One DES encryption, positions counted from 1 at the MSB
    function automatic logic [63:0] des_encrypt_block(input logic [63:0] key,
                                                      input logic [63:0] blk);
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        logic [55:0] cdr;
        logic [63:0] lr;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] nr;
        logic [47:0] sub;
        logic [47:0] ex;
        logic [31:0] sb;
        logic [31:0] pf;
        logic [5:0]  six;
        logic [63:0] pre;
        logic [63:0] res;
        for (int i = 0; i < 56; i++) cd[55-i] = key[64-TAB_PC1[i]];
        c = cd[55:28];
        d = cd[27:0];
        for (int i = 0; i < 64; i++) lr[63-i] = blk[64-TAB_IP[i]];
        l = lr[63:32];
        r = lr[31:0];
        for (int rnd = 0; rnd < 16; rnd++)
        begin
            for (int s = 0; s < TAB_ROT[rnd]; s++)
            begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            cdr = {c, d};
            for (int i = 0; i < 48; i++) sub[47-i] = cdr[56-TAB_PC2[i]];
            for (int i = 0; i < 48; i++) ex[47-i] = r[32-TAB_E[i]];
            ex = ex ^ sub;
            for (int b = 0; b < 8; b++)
            begin
                six = ex[47-6*b -: 6];
                sb[31-4*b -: 4] = SBOX[b][{six[5], six[0], six[4:1]}];
            end
            for (int i = 0; i < 32; i++) pf[31-i] = sb[32-TAB_P[i]];
            nr = l ^ pf;
            l = r;
            r = nr;
        end
        pre = {r, l};
        for (int i = 0; i < 64; i++) res[63-i] = pre[64-TAB_FP[i]];
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sink ready: random stalls plus an on-demand long hold
    always @(posedge clk)
    begin
        if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            dout.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            dout.ready <= 1'b0;
        end
        else if (!sink_stalls)
            dout.ready <= 1'b1;
        else
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 85)
                dout.ready <= 1'b1;
            else
            begin
                dout.ready <= 1'b0;
                stall_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(9, 39);
            end
        end
    end

    // Check each ciphertext beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && dout.valid && dout.ready)
        begin
            if (cipher_expected.size() == 0)
            begin
                $error("unexpected beat: ciphertext_block %h", dout.ciphertext_block);
                mismatch_count++;
            end
            else
            begin
                logic [63:0] want;
                want = cipher_expected.pop_front();
                if (dout.ciphertext_block !== want)
                begin
                    $error("ciphertext_block expected %h actual %h", want,
                           dout.ciphertext_block);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if ((din.valid && din.ready) || (dout.valid && dout.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Send one plaintext beat and record its expected ciphertext
    task automatic send_block(input logic [63:0] pt, input bit som);
        int gap;
        logic [63:0] ks;
        gap = send_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            din.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din.valid            <= 1'b1;
        din.plaintext_block  <= pt;
        din.start_of_message <= som;
        do @(posedge clk); while (!din.ready);
        if (som)
            feedback_shadow = iv_shadow;
        ks = des_encrypt_block(key_shadow, feedback_shadow);
        feedback_shadow = ks;
        cipher_expected.push_back(pt ^ ks);
    endtask

    // Drop valid, wait until every expected beat has come out, then let the chain settle
    task automatic drain();
        din.valid <= 1'b0;
        while (cipher_expected.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_KEY)
            key_shadow = value;
        else
            iv_shadow = value;
    endtask

    // Blocks before any start, field extremes, key change mid-message
    task automatic test_directed();
        send_gaps   = 1'b0;
        sink_stalls = 1'b0;
        send_block(64'h0, 1'b0);
        send_block({64{1'b1}}, 1'b0);
        send_block(64'h0, 1'b1);
        write_reg(CFG_KEY, {64{1'b1}});
        write_reg(CFG_IV, {64{1'b1}});
        send_block({64{1'b1}}, 1'b1);
        send_block(64'h0, 1'b0);
        send_block(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        write_reg(CFG_KEY, 64'h1334_5779_9BBC_DFF1);
        send_block(64'h5555_5555_5555_5555, 1'b0);
        write_reg(CFG_IV, 64'h0123_4567_89AB_CDEF);
        send_block(64'h0, 1'b0);
        send_block(64'h0123_4567_89AB_CDEF, 1'b1);
        send_block(64'h8000_0000_0000_0001, 1'b0);
        write_reg(CFG_KEY, 64'h0);
        write_reg(CFG_IV, 64'h0);
        send_block({64{1'b1}}, 1'b1);
        send_block(64'h0, 1'b1);
        drain();
    endtask

    // Random messages under random settings, with gaps and stalls
    task automatic test_random_messages(input int n_items);
        int sent;
        int len;
        send_gaps   = 1'b1;
        sink_stalls = 1'b1;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                write_reg(CFG_KEY, rand64());
                write_reg(CFG_IV, rand64());
                send_gaps   = $urandom_range(0, 3) != 0;
                sink_stalls = $urandom_range(0, 3) != 0;
            end
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                send_block(rand64(), (i == 0) && ($urandom_range(0, 9) != 0));
            sent += len;
        end
        drain();
    endtask

    // Long sink hold while the source keeps offering beats
    task automatic test_backpressure();
        send_gaps = 1'b0;
        long_hold_req = 1'b1;
        for (int i = 0; i < 24; i++)
            send_block(rand64(), (i % 6) == 0);
        // Pause the source until everything has come out, then resume
        drain();
        for (int i = 0; i < 8; i++)
            send_block(rand64(), i == 0);
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_KEY;
        cfg_data = 64'h0;
        din.valid = 1'b0;
        din.plaintext_block = 64'h0;
        din.start_of_message = 1'b0;
        key_shadow = 64'h0;
        iv_shadow = 64'h0;
        feedback_shadow = 64'h0;
        mismatch_count = 0;
        long_hold_req = 1'b0;
        send_gaps = 1'b0;
        sink_stalls = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_messages(800);
        test_backpressure();
        test_random_messages(760);

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> des_ofb_stream_cipher_top.f
+incdir+rtl
rtl/desofb_pkg.sv
rtl/desofb_in_if.sv
rtl/desofb_out_if.sv
rtl/desofb_round_cell.sv
rtl/des_ofb_stream_cipher_top.sv
test/tb_des_ofb_stream_cipher_top.sv
